[rtl/core/erm_pkg.sv]
`default_nettype none

package erm_pkg;

   // binary angle turn is 2^ANGLE_BITS, elements carry FRAC_BITS fraction bits
   localparam int ANGLE_BITS = 16;
   localparam int FRAC_BITS = 14;

   localparam int ANG_W = 16;
   localparam int ELEM_W = 16;
   localparam int LANES = 3;

   // last term of the sine/cosine power series
   localparam int SERIES_LAST = 20;

   // pi/2 in Q32 is 2^32 + HALFPI_LO
   localparam logic [31:0] HALFPI_LO = 32'h921F_B544;

   // quadrant codes from the top two bits of the turn
   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   // where a series term goes, chosen by term index mod 4
   localparam int TERM_COS_ADD = 0;
   localparam int TERM_SIN_ADD = 1;
   localparam int TERM_COS_SUB = 2;
   localparam int TERM_SIN_SUB = 3;

   typedef struct packed {
      logic [ANG_W-1:0] first_angle;
      logic [ANG_W-1:0] second_angle;
      logic [ANG_W-1:0] third_angle;
   } req_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] m00;
      logic signed [ELEM_W-1:0] m01;
      logic signed [ELEM_W-1:0] m02;
      logic signed [ELEM_W-1:0] m10;
      logic signed [ELEM_W-1:0] m11;
      logic signed [ELEM_W-1:0] m12;
      logic signed [ELEM_W-1:0] m20;
      logic signed [ELEM_W-1:0] m21;
      logic signed [ELEM_W-1:0] m22;
   } rsp_type;

   // one angle's series evaluation in flight
   typedef struct packed {
      logic [1:0]         quad;
      logic [31:0]        x;
      logic [31:0]        t;
      logic signed [33:0] sacc;
      logic signed [33:0] cacc;
   } lane_type;

   typedef struct packed {
      logic                      vld;
      lane_type [LANES-1:0]      lane;
   } series_type;

   // Q30 sine and cosine of phi, theta, psi (lanes 0, 1, 2)
   typedef struct packed {
      logic                      vld;
      logic [LANES-1:0][31:0]    sn;
      logic [LANES-1:0][31:0]    cs;
   } trig_type;

endpackage

`default_nettype wire

[rtl/core/euler_rotation_matrix.sv]
// Throughput: one request per cycle while the result is not stalled; depth is set by the
// 19 series-term units of the sine/cosine chain at three register stages each, plus front
// end and matrix stages.
// A stall on the result side freezes every stage together; nothing is dropped or repeated.
// Reset: synchronous, active high; clears all valid bits, no result is pending afterward.
`default_nettype none

module euler_rotation_matrix (
   input  var logic             clock,
   input  var logic             reset,
   input  var logic             req_valid,
   output logic                 req_stall,
   input  var erm_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  var logic             rsp_stall,
   output erm_pkg::rsp_type     rsp_data
);

   logic              adv;
   erm_pkg::trig_type trig;

   // pipeline moves unless a finished result is held up
   assign adv = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   erm_sincos u_sincos (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .req_valid (req_valid),
      .req_data  (req_data),
      .trig      (trig)
   );

   erm_matrix u_matrix (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .trig     (trig),
      .out_vld  (rsp_valid),
      .out_data (rsp_data)
   );

endmodule

`default_nettype wire

[rtl/core/erm_term.sv]
`default_nettype none

// One power series term: t_n = (t_(n-1) * x + n*2^30) / (n*2^31), in three stages.
module erm_term #(
   parameter int N = 2
) (
   input  var logic                clock,
   input  var logic                reset,
   input  var logic                adv,
   input  var erm_pkg::series_type stage_in,
   output erm_pkg::series_type     stage_out
);

   localparam logic [63:0] BIAS = 64'(N) << 30;
   localparam logic [32:0] DIV = 33'(N);
   localparam int SEL = N % 4;

   logic                                    s1_vld_ff;
   erm_pkg::lane_type [erm_pkg::LANES-1:0]  s1_lane_ff;
   logic [erm_pkg::LANES-1:0][32:0]         s1_p_ff, s1_p_in;

   logic                                    s2_vld_ff;
   erm_pkg::lane_type [erm_pkg::LANES-1:0]  s2_lane_ff;
   logic [erm_pkg::LANES-1:0][32:0]         s2_p_ff;
   logic [erm_pkg::LANES-1:0][32:0]         s2_q_ff, s2_q_in;

   logic                                    s3_vld_ff;
   erm_pkg::lane_type [erm_pkg::LANES-1:0]  s3_lane_ff, s3_lane_in;

   for (genvar i = 0; i < erm_pkg::LANES; i++) begin : g_lane
      logic [63:0] prod;
      logic [32:0] rem;
      logic [31:0] t_new;
      logic signed [33:0] t_ext;

      // stage 1: scaled product, pre-divided by 2^31
      assign prod = 64'(stage_in.lane[i].t) * 64'(stage_in.lane[i].x);
      assign s1_p_in[i] = 33'((prod + BIAS) >> 31);

      // stage 2: quotient estimate, exact or one low
      if ((N & (N - 1)) == 0) begin : g_pow2
         localparam int SHIFT = $clog2(N);
         assign s2_q_in[i] = s1_p_ff[i] >> SHIFT;
      end else begin : g_recip
         localparam logic [32:0] RECIP = 33'((64'd1 << 33) / N);
         logic [65:0] rprod;
         assign rprod = 66'(s1_p_ff[i]) * 66'(RECIP);
         assign s2_q_in[i] = rprod[65:33];
      end

      // stage 3: fix the estimate and fold the term into its sum
      assign rem = s2_p_ff[i] - 33'(s2_q_ff[i] * DIV);
      assign t_new = (rem >= DIV) ? 32'(s2_q_ff[i] + 33'd1) : 32'(s2_q_ff[i]);
      assign t_ext = $signed({2'b00, t_new});

      always_comb begin
         s3_lane_in[i] = s2_lane_ff[i];
         s3_lane_in[i].t = t_new;
         if (SEL == erm_pkg::TERM_SIN_ADD) begin
            s3_lane_in[i].sacc = $signed(s2_lane_ff[i].sacc) + t_ext;
         end else if (SEL == erm_pkg::TERM_COS_SUB) begin
            s3_lane_in[i].cacc = $signed(s2_lane_ff[i].cacc) - t_ext;
         end else if (SEL == erm_pkg::TERM_SIN_SUB) begin
            s3_lane_in[i].sacc = $signed(s2_lane_ff[i].sacc) - t_ext;
         end else begin
            s3_lane_in[i].cacc = $signed(s2_lane_ff[i].cacc) + t_ext;
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= stage_in.vld;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_lane_ff <= stage_in.lane;
         s1_p_ff    <= s1_p_in;
         s2_lane_ff <= s1_lane_ff;
         s2_p_ff    <= s1_p_ff;
         s2_q_ff    <= s2_q_in;
         s3_lane_ff <= s3_lane_in;
      end
   end

   assign stage_out = {s3_vld_ff, s3_lane_ff};

endmodule

`default_nettype wire

[rtl/core/erm_sincos.sv]
`default_nettype none

// Sine and cosine of the three angles in Q30 through a chain of series terms.
module erm_sincos (
   input  var logic              clock,
   input  var logic              reset,
   input  var logic              adv,
   input  var logic              req_valid,
   input  var erm_pkg::req_type  req_data,
   output erm_pkg::trig_type     trig
);

   localparam logic [31:0] AMASK = 32'((64'd1 << erm_pkg::ANGLE_BITS) - 64'd1);
   localparam logic [63:0] X_ROUND = 64'd1 << 30;
   localparam logic signed [33:0] COS_START = 34'sd1 <<< 31;

   logic [erm_pkg::LANES-1:0][erm_pkg::ANG_W-1:0] ang;

   logic                                    f1_vld_ff;
   logic [erm_pkg::LANES-1:0][1:0]          f1_quad_ff, f1_quad_in;
   logic [erm_pkg::LANES-1:0][29:0]         f1_r_ff, f1_r_in;
   logic [erm_pkg::LANES-1:0][61:0]         f1_lo_ff, f1_lo_in;

   logic                                    f2_vld_ff;
   erm_pkg::lane_type [erm_pkg::LANES-1:0]  f2_lane_ff, f2_lane_in;

   erm_pkg::series_type chain [1:erm_pkg::SERIES_LAST];

   logic                                    fold_vld_ff;
   logic [erm_pkg::LANES-1:0][31:0]         sn_ff, sn_in;
   logic [erm_pkg::LANES-1:0][31:0]         cs_ff, cs_in;

   assign ang[0] = req_data.first_angle;
   assign ang[1] = req_data.second_angle;
   assign ang[2] = req_data.third_angle;

   for (genvar i = 0; i < erm_pkg::LANES; i++) begin : g_front
      logic [31:0] u;
      logic [63:0] xsum;
      logic [31:0] x;

      // turn scaled to 32 bits: quadrant on top, Q30 fraction below
      assign u = (32'(ang[i]) & AMASK) << (32 - erm_pkg::ANGLE_BITS);
      assign f1_quad_in[i] = u[31:30];
      assign f1_r_in[i] = u[29:0];
      assign f1_lo_in[i] = 62'(u[29:0]) * 62'(erm_pkg::HALFPI_LO);

      // base angle in radians, Q31; first term equals x
      assign xsum = 64'({f1_r_ff[i], 32'd0}) + 64'(f1_lo_ff[i]) + X_ROUND;
      assign x = xsum[62:31];

      always_comb begin
         f2_lane_in[i].quad = f1_quad_ff[i];
         f2_lane_in[i].x    = x;
         f2_lane_in[i].t    = x;
         f2_lane_in[i].sacc = $signed({2'b00, x});
         f2_lane_in[i].cacc = COS_START;
      end
   end

   assign chain[1] = {f2_vld_ff, f2_lane_ff};

   for (genvar n = 2; n <= erm_pkg::SERIES_LAST; n++) begin : g_term
      erm_term #(
         .N(n)
      ) u_term (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .stage_in  (chain[n-1]),
         .stage_out (chain[n])
      );
   end

   // round sums to Q30 and unfold the quadrant
   for (genvar i = 0; i < erm_pkg::LANES; i++) begin : g_fold
      logic signed [33:0] sb_wide, cb_wide;
      logic signed [31:0] sb, cb;

      assign sb_wide = ($signed(chain[erm_pkg::SERIES_LAST].lane[i].sacc) + 34'sd1) >>> 1;
      assign cb_wide = ($signed(chain[erm_pkg::SERIES_LAST].lane[i].cacc) + 34'sd1) >>> 1;
      assign sb = 32'(sb_wide);
      assign cb = 32'(cb_wide);

      always_comb begin
         case (chain[erm_pkg::SERIES_LAST].lane[i].quad)
            erm_pkg::QUAD_0: begin
               sn_in[i] = sb;
               cs_in[i] = cb;
            end
            erm_pkg::QUAD_1: begin
               sn_in[i] = cb;
               cs_in[i] = -sb;
            end
            erm_pkg::QUAD_2: begin
               sn_in[i] = -sb;
               cs_in[i] = -cb;
            end
            default: begin
               // fourth quadrant
               sn_in[i] = -cb;
               cs_in[i] = sb;
            end
         endcase
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff   <= 1'b0;
         f2_vld_ff   <= 1'b0;
         fold_vld_ff <= 1'b0;
      end else if (adv) begin
         f1_vld_ff   <= req_valid;
         f2_vld_ff   <= f1_vld_ff;
         fold_vld_ff <= chain[erm_pkg::SERIES_LAST].vld;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (adv) begin
         f1_quad_ff <= f1_quad_in;
         f1_r_ff    <= f1_r_in;
         f1_lo_ff   <= f1_lo_in;
         f2_lane_ff <= f2_lane_in;
         sn_ff      <= sn_in;
         cs_ff      <= cs_in;
      end
   end

   assign trig = {fold_vld_ff, sn_ff, cs_ff};

endmodule

`default_nettype wire

[rtl/core/erm_matrix.sv]
`default_nettype none

// Products, sums and rounding of the nine matrix elements.
module erm_matrix (
   input  var logic              clock,
   input  var logic              reset,
   input  var logic              adv,
   input  var erm_pkg::trig_type trig,
   output logic                  out_vld,
   output erm_pkg::rsp_type      out_data
);

   localparam logic signed [63:0] HALF_Q30 = 64'sd1 <<< 29;
   localparam logic signed [63:0] ROUND = 64'sd1 <<< (59 - erm_pkg::FRAC_BITS);
   localparam logic signed [63:0] ONE = 64'sd1 <<< erm_pkg::FRAC_BITS;
   localparam int FIN_SHIFT = 60 - erm_pkg::FRAC_BITS;

   // round a Q60 element to the output scale and clamp to plus or minus one
   function automatic logic signed [erm_pkg::ELEM_W-1:0] finish(
      input logic signed [63:0] v
   );
      logic signed [63:0] e;
      e = (v + ROUND) >>> FIN_SHIFT;
      if (e > ONE) begin
         e = ONE;
      end else if (e < -ONE) begin
         e = -ONE;
      end
      return e[erm_pkg::ELEM_W-1:0];
   endfunction

   logic signed [31:0] sf, cf, st, ct, sp, cp;

   logic               m1_vld_ff;
   logic signed [63:0] m1_cfct_ff, m1_sfct_ff, m1_sfsp_ff, m1_cfsp_ff, m1_sfcp_ff;
   logic signed [63:0] m1_cfcp_ff, m1_stcp_ff, m1_stsp_ff, m1_cfst_ff, m1_sfst_ff;
   logic signed [31:0] m1_cp_ff, m1_sp_ff, m1_ct_ff;

   logic               m2_vld_ff;
   logic signed [31:0] m2_cfct_ff, m2_cfct_in, m2_sfct_ff, m2_sfct_in;
   logic signed [63:0] m2_sfsp_ff, m2_cfsp_ff, m2_sfcp_ff, m2_cfcp_ff;
   logic signed [63:0] m2_stcp_ff, m2_stsp_ff, m2_cfst_ff, m2_sfst_ff;
   logic signed [31:0] m2_cp_ff, m2_sp_ff, m2_ct_ff;

   logic               m3_vld_ff;
   logic signed [63:0] m3_cc_ff, m3_sc_ff, m3_cs_ff, m3_ss_ff;
   logic signed [63:0] m3_sfsp_ff, m3_cfsp_ff, m3_sfcp_ff, m3_cfcp_ff;
   logic signed [63:0] m3_stcp_ff, m3_stsp_ff, m3_cfst_ff, m3_sfst_ff;
   logic signed [31:0] m3_ct_ff;

   logic               m4_vld_ff;
   logic signed [63:0] m4_elem_ff [0:8];
   logic signed [63:0] m4_elem_in [0:8];

   logic               out_vld_ff;
   erm_pkg::rsp_type   out_data_ff, out_data_in;

   assign sf = $signed(trig.sn[0]);
   assign cf = $signed(trig.cs[0]);
   assign st = $signed(trig.sn[1]);
   assign ct = $signed(trig.cs[1]);
   assign sp = $signed(trig.sn[2]);
   assign cp = $signed(trig.cs[2]);

   // first-pair products round to Q30 before the third factor
   assign m2_cfct_in = 32'((m1_cfct_ff + HALF_Q30) >>> 30);
   assign m2_sfct_in = 32'((m1_sfct_ff + HALF_Q30) >>> 30);

   // element sums in Q60
   always_comb begin
      m4_elem_in[0] = m3_cc_ff - m3_sfsp_ff;
      m4_elem_in[1] = m3_sc_ff + m3_cfsp_ff;
      m4_elem_in[2] = -m3_stcp_ff;
      m4_elem_in[3] = -m3_cs_ff - m3_sfcp_ff;
      m4_elem_in[4] = -m3_ss_ff + m3_cfcp_ff;
      m4_elem_in[5] = m3_stsp_ff;
      m4_elem_in[6] = m3_cfst_ff;
      m4_elem_in[7] = m3_sfst_ff;
      m4_elem_in[8] = 64'(m3_ct_ff) <<< 30;
   end

   // final rounding and clamp
   always_comb begin
      out_data_in.m00 = finish(m4_elem_ff[0]);
      out_data_in.m01 = finish(m4_elem_ff[1]);
      out_data_in.m02 = finish(m4_elem_ff[2]);
      out_data_in.m10 = finish(m4_elem_ff[3]);
      out_data_in.m11 = finish(m4_elem_ff[4]);
      out_data_in.m12 = finish(m4_elem_ff[5]);
      out_data_in.m20 = finish(m4_elem_ff[6]);
      out_data_in.m21 = finish(m4_elem_ff[7]);
      out_data_in.m22 = finish(m4_elem_ff[8]);
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         m1_vld_ff  <= 1'b0;
         m2_vld_ff  <= 1'b0;
         m3_vld_ff  <= 1'b0;
         m4_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         m1_vld_ff  <= trig.vld;
         m2_vld_ff  <= m1_vld_ff;
         m3_vld_ff  <= m2_vld_ff;
         m4_vld_ff  <= m3_vld_ff;
         out_vld_ff <= m4_vld_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (adv) begin
         // pair products
         m1_cfct_ff <= cf * ct;
         m1_sfct_ff <= sf * ct;
         m1_sfsp_ff <= sf * sp;
         m1_cfsp_ff <= cf * sp;
         m1_sfcp_ff <= sf * cp;
         m1_cfcp_ff <= cf * cp;
         m1_stcp_ff <= st * cp;
         m1_stsp_ff <= st * sp;
         m1_cfst_ff <= cf * st;
         m1_sfst_ff <= sf * st;
         m1_cp_ff   <= cp;
         m1_sp_ff   <= sp;
         m1_ct_ff   <= ct;

         m2_cfct_ff <= m2_cfct_in;
         m2_sfct_ff <= m2_sfct_in;
         m2_sfsp_ff <= m1_sfsp_ff;
         m2_cfsp_ff <= m1_cfsp_ff;
         m2_sfcp_ff <= m1_sfcp_ff;
         m2_cfcp_ff <= m1_cfcp_ff;
         m2_stcp_ff <= m1_stcp_ff;
         m2_stsp_ff <= m1_stsp_ff;
         m2_cfst_ff <= m1_cfst_ff;
         m2_sfst_ff <= m1_sfst_ff;
         m2_cp_ff   <= m1_cp_ff;
         m2_sp_ff   <= m1_sp_ff;
         m2_ct_ff   <= m1_ct_ff;

         // three-factor products
         m3_cc_ff   <= m2_cfct_ff * m2_cp_ff;
         m3_sc_ff   <= m2_sfct_ff * m2_cp_ff;
         m3_cs_ff   <= m2_cfct_ff * m2_sp_ff;
         m3_ss_ff   <= m2_sfct_ff * m2_sp_ff;
         m3_sfsp_ff <= m2_sfsp_ff;
         m3_cfsp_ff <= m2_cfsp_ff;
         m3_sfcp_ff <= m2_sfcp_ff;
         m3_cfcp_ff <= m2_cfcp_ff;
         m3_stcp_ff <= m2_stcp_ff;
         m3_stsp_ff <= m2_stsp_ff;
         m3_cfst_ff <= m2_cfst_ff;
         m3_sfst_ff <= m2_sfst_ff;
         m3_ct_ff   <= m2_ct_ff;

         m4_elem_ff  <= m4_elem_in;
         out_data_ff <= out_data_in;
      end
   end

   assign out_vld = out_vld_ff;
   assign out_data = out_data_ff;

endmodule

`default_nettype wire

[rtl/core/erm_checker.sv]
`default_nettype none

module erm_checker (
   input var logic             clock,
   input var logic             reset,
   input var logic             req_valid,
   input var logic             req_stall,
   input var erm_pkg::req_type req_data,
   input var logic             rsp_valid,
   input var logic             rsp_stall,
   input var erm_pkg::rsp_type rsp_data
);

   localparam logic signed [erm_pkg::ELEM_W-1:0] ELEM_ONE =
      erm_pkg::ELEM_W'(1 << erm_pkg::FRAC_BITS);

   function automatic logic in_range(input logic signed [erm_pkg::ELEM_W-1:0] v);
      return (v <= ELEM_ONE) && (v >= -ELEM_ONE);
   endfunction

   logic req_seen;
   assign req_seen = req_valid || (req_data == req_data);

   // a held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // the input side is only held back by a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_seen && req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stalled result");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // every element is clamped to plus or minus one
   a_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> in_range(rsp_data.m00) && in_range(rsp_data.m01) &&
         in_range(rsp_data.m02) && in_range(rsp_data.m10) && in_range(rsp_data.m11) &&
         in_range(rsp_data.m12) && in_range(rsp_data.m20) && in_range(rsp_data.m21) &&
         in_range(rsp_data.m22))
      else $error("matrix element out of range");

endmodule

bind euler_rotation_matrix erm_checker u_checker (.*);

`default_nettype wire
